### rtl/core/owhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owhd_pkg
// Shared types, constants, microcode field codes and the sine table of the
// omni wheel heading drive.
// ----------------------------------------------------------------------------
package owhd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM = 2'd1;
	localparam logic [CFG_DATA_W-1:0] SPEED_RST   = 10'd100;
	localparam logic [CFG_DATA_W-1:0] MAX_RPM_RST = 10'd200;

	localparam int unsigned DRIVE_TOP_DEF = 249;

	// Command codes
	localparam logic [7:0] CMD_MOVE = 8'd1;
	localparam logic [7:0] CMD_STOP = 8'd90;

	// Coupling matrix in Q1.15
	localparam int COEF_TWO_THIRDS = 21846;
	localparam int COEF_THIRD      = 10922;
	localparam int COEF_ROOT       = 18920;
	localparam int VEL_SHIFT       = 6;
	localparam int PROD_SHIFT      = 24;

	// Datapath widths
	localparam int HEAD_W  = 10;
	localparam int VEL_W   = 20;
	localparam int ANG_W   = 9;
	localparam int ANGX_W  = 11;
	localparam int SIN_W   = 16;
	localparam int MUL_A_W = 20;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int DRV_W   = 9;
	localparam int QUOT_W  = 9;
	localparam int REM_W   = CFG_DATA_W + QUOT_W;
	localparam int CNT_W   = 4;
	localparam int STEP_W  = 5;

	// sin(k degrees) * 32768 for k = 0..90, the last entry saturated
	localparam logic [14:0] SIN_Q15 [91] = '{
		15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
		15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
		15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
		15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
		15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
		15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
		15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
		15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
		15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
		15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
		15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
		15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
		15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
		15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
		15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
		15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
		15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588,
		15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
		15'd32767
	};

	// Microcode field codes
	typedef enum logic [1:0] {A_SIN, A_VX, A_VY} mul_a_t;
	typedef enum logic [2:0] {B_SPEED, B_W1, B_THIRD, B_NROOT, B_ROOT} mul_b_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic [1:0] {VEL_HOLD, VEL_STOP, VEL_X, VEL_Y} vel_op_t;
	typedef enum logic [1:0] {DIV_HOLD, DIV_INIT, DIV_STEP} div_op_t;
	typedef enum logic [1:0] {DRV_HOLD, DRV_ONE, DRV_TWO, DRV_THREE} drv_op_t;
	typedef enum logic [2:0] {
		JMP_NEXT, JMP_ALWAYS, JMP_NO_INPUT, JMP_NOT_MOVE, JMP_DIV_MORE, JMP_OUT_FULL
	} jump_t;

	// One control word
	typedef struct packed {
		logic              in_rdy;
		logic              ang_ld;
		logic              ang_cos;
		logic              sin_ld;
		logic              mul_en;
		mul_a_t            mul_a;
		mul_b_t            mul_b;
		acc_op_t           acc_op;
		vel_op_t           vel_op;
		div_op_t           div_op;
		drv_op_t           drv_op;
		logic              out_ld;
		jump_t             jump;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// Status returned to the sequencer for its jump conditions
	typedef struct packed {
		logic in_valid;
		logic move;
		logic div_more;
		logic out_full;
	} stat_t;

endpackage
`default_nettype wire

### rtl/core/owhd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owhd_in_if
// Packet channel: one received sound-direction packet per item.
// ----------------------------------------------------------------------------
interface owhd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] az_first;
	logic [7:0] az_second;
	logic [7:0] command;
	logic       data_fresh;

	modport source (output valid, output az_first, output az_second, output command,
		output data_fresh, input ready);
	modport sink (input valid, input az_first, input az_second, input command,
		input data_fresh, output ready);
endinterface
`default_nettype wire

### rtl/core/owhd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owhd_out_if
// Drive channel: one set of three signed wheel drive values per item.
// ----------------------------------------------------------------------------
interface owhd_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] drive_one;
	logic signed [8:0] drive_two;
	logic signed [8:0] drive_three;

	modport source (output valid, output drive_one, output drive_two,
		output drive_three, input ready);
	modport sink (input valid, input drive_one, input drive_two,
		input drive_three, output ready);
endinterface
`default_nettype wire

### rtl/core/owhd_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owhd_sequencer
// Step counter and microcode ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module owhd_sequencer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire owhd_pkg::stat_t stat,
	output owhd_pkg::ctrl_t      ctrl
);
	import owhd_pkg::*;

	localparam logic [STEP_W-1:0] S_WAIT  = 5'd0;
	localparam logic [STEP_W-1:0] S_WHEEL = 5'd7;
	localparam logic [STEP_W-1:0] S_DIV1  = 5'd10;
	localparam logic [STEP_W-1:0] S_DIV2  = 5'd15;
	localparam logic [STEP_W-1:0] S_DIV3  = 5'd20;
	localparam logic [STEP_W-1:0] S_OUT   = 5'd22;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
		ctrl_t w;
		w = '0;
		case (s)
			5'd0: begin
				w.in_rdy = 1'b1;
				w.jump   = JMP_NO_INPUT;
				w.target = S_WAIT;
			end
			5'd1: begin
				w.vel_op = VEL_STOP;
				w.jump   = JMP_NOT_MOVE;
				w.target = S_WHEEL;
			end
			5'd2: w.ang_ld = 1'b1;
			5'd3: begin
				w.sin_ld  = 1'b1;
				w.ang_ld  = 1'b1;
				w.ang_cos = 1'b1;
			end
			5'd4: begin
				w.sin_ld = 1'b1;
				w.mul_en = 1'b1;
				w.mul_a  = A_SIN;
				w.mul_b  = B_SPEED;
			end
			5'd5: begin
				w.vel_op = VEL_X;
				w.mul_en = 1'b1;
				w.mul_a  = A_SIN;
				w.mul_b  = B_SPEED;
			end
			5'd6: w.vel_op = VEL_Y;
			5'd7: begin
				w.mul_en = 1'b1;
				w.mul_a  = A_VX;
				w.mul_b  = B_W1;
			end
			5'd8:  w.acc_op = ACC_LOAD;
			5'd9:  w.div_op = DIV_INIT;
			5'd10: begin
				w.div_op = DIV_STEP;
				w.jump   = JMP_DIV_MORE;
				w.target = S_DIV1;
			end
			5'd11: begin
				w.drv_op = DRV_ONE;
				w.mul_en = 1'b1;
				w.mul_a  = A_VX;
				w.mul_b  = B_THIRD;
			end
			5'd12: begin
				w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1;
				w.mul_a  = A_VY;
				w.mul_b  = B_NROOT;
			end
			5'd13: w.acc_op = ACC_ADD;
			5'd14: w.div_op = DIV_INIT;
			5'd15: begin
				w.div_op = DIV_STEP;
				w.jump   = JMP_DIV_MORE;
				w.target = S_DIV2;
			end
			5'd16: begin
				w.drv_op = DRV_TWO;
				w.mul_en = 1'b1;
				w.mul_a  = A_VX;
				w.mul_b  = B_THIRD;
			end
			5'd17: begin
				w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1;
				w.mul_a  = A_VY;
				w.mul_b  = B_ROOT;
			end
			5'd18: w.acc_op = ACC_ADD;
			5'd19: w.div_op = DIV_INIT;
			5'd20: begin
				w.div_op = DIV_STEP;
				w.jump   = JMP_DIV_MORE;
				w.target = S_DIV3;
			end
			5'd21: w.drv_op = DRV_THREE;
			5'd22: begin
				w.out_ld = 1'b1;
				w.jump   = JMP_OUT_FULL;
				w.target = S_OUT;
			end
			default: begin
				w.jump   = JMP_ALWAYS;
				w.target = S_WAIT;
			end
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic              take;

	assign ctrl = ucode(step_q);

	always_comb begin
		unique case (ctrl.jump)
			JMP_NEXT:     take = 1'b0;
			JMP_ALWAYS:   take = 1'b1;
			JMP_NO_INPUT: take = !stat.in_valid;
			JMP_NOT_MOVE: take = !stat.move;
			JMP_DIV_MORE: take = stat.div_more;
			JMP_OUT_FULL: take = stat.out_full;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else if (take) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/owhd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owhd_datapath
// Heading, velocity and configuration registers, one shared multiplier, an
// accumulator, a bounded restoring divider and the output register.
// ----------------------------------------------------------------------------
module owhd_datapath #(
	parameter int unsigned DRIVE_TOP = owhd_pkg::DRIVE_TOP_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire owhd_pkg::ctrl_t                  ctrl,
	output owhd_pkg::stat_t                       stat,
	input  wire logic                             cfg_we,
	input  wire logic [owhd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [owhd_pkg::CFG_DATA_W-1:0] cfg_data,
	owhd_in_if.sink                               pkt,
	owhd_out_if.source                            drive
);
	import owhd_pkg::*;

	// Wheel coefficients already scaled by the full drive value
	localparam logic signed [MUL_B_W-1:0] K_W1 =
		MUL_B_W'(-(COEF_TWO_THIRDS * int'(DRIVE_TOP)));
	localparam logic signed [MUL_B_W-1:0] K_THIRD = MUL_B_W'(COEF_THIRD * int'(DRIVE_TOP));
	localparam logic signed [MUL_B_W-1:0] K_NROOT =
		MUL_B_W'(-(COEF_ROOT * int'(DRIVE_TOP)));
	localparam logic signed [MUL_B_W-1:0] K_ROOT = MUL_B_W'(COEF_ROOT * int'(DRIVE_TOP));
	localparam logic [DRV_W-1:0] LIM_POS = (DRIVE_TOP < 255) ? DRV_W'(DRIVE_TOP) : 9'd255;
	localparam logic [DRV_W-1:0] LIM_NEG = (DRIVE_TOP < 256) ? DRV_W'(DRIVE_TOP) : 9'd256;

	logic [CFG_DATA_W-1:0]    speed_q, max_rpm_q;
	logic signed [HEAD_W-1:0] heading_q;
	logic                     move_q, stop_q;
	logic signed [VEL_W-1:0]  vel_x_q, vel_y_q;
	logic [ANG_W-1:0]         angle_q;
	logic signed [SIN_W-1:0]  sin_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [REM_W-1:0]         rem_q;
	logic [QUOT_W-1:0]        quot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q, sat_q;
	logic signed [DRV_W-1:0]  drv1_q, drv2_q, drv3_q;
	logic signed [DRV_W-1:0]  out1_q, out2_q, out3_q;
	logic                     out_valid_q;

	logic                      accept;
	logic [8:0]                az_sum;
	logic signed [HEAD_W-1:0]  head_new;
	logic [ANGX_W-1:0]         ang_ext;
	logic [ANG_W-1:0]          ang_red;
	logic [ANG_W-1:0]          fold_diff;
	logic [6:0]                sin_idx;
	logic                      sin_neg;
	logic signed [SIN_W-1:0]   sin_val;
	logic signed [MUL_A_W-1:0] mul_a_val;
	logic signed [MUL_B_W-1:0] mul_b_val;
	logic [PROD_W-1:0]         prod_abs;
	logic [VEL_W-1:0]          vel_mag;
	logic [ACC_W-1:0]          acc_abs;
	logic [ACC_W-PROD_SHIFT-1:0] div_num;
	logic [CFG_DATA_W-1:0]     rpm_eff;
	logic [REM_W-1:0]          dvs;
	logic                      rem_ge;
	logic [DRV_W-1:0]          drv_lim, drv_mag;
	logic signed [DRV_W-1:0]   drv_val;
	logic                      out_full;

	// Handshake and status
	assign accept         = pkt.valid && ctrl.in_rdy;
	assign pkt.ready      = ctrl.in_rdy;
	assign out_full       = out_valid_q && !drive.ready;
	assign stat.in_valid  = pkt.valid;
	assign stat.move      = move_q;
	assign stat.div_more  = (cnt_q != '0);
	assign stat.out_full  = out_full;
	assign drive.valid       = out_valid_q;
	assign drive.drive_one   = out1_q;
	assign drive.drive_two   = out2_q;
	assign drive.drive_three = out3_q;

	// Azimuth from the packet bytes
	always_comb begin
		az_sum = 9'(pkt.az_first) + 9'(pkt.az_second);
		if (pkt.az_first >= pkt.az_second) begin
			head_new = signed'(HEAD_W'(az_sum));
		end else begin
			head_new = signed'(HEAD_W'(10'd0 - HEAD_W'(az_sum)));
		end
	end

	// Reduce heading (plus a quarter turn for cosine) to 0..359
	always_comb begin
		ang_ext = ANGX_W'({heading_q[HEAD_W-1], heading_q}) + 11'd720
			+ (ctrl.ang_cos ? 11'd90 : 11'd0);
		priority if (ang_ext >= 11'd1080) begin
			ang_red = ANG_W'(ang_ext - 11'd1080);
		end else if (ang_ext >= 11'd720) begin
			ang_red = ANG_W'(ang_ext - 11'd720);
		end else if (ang_ext >= 11'd360) begin
			ang_red = ANG_W'(ang_ext - 11'd360);
		end else begin
			ang_red = ANG_W'(ang_ext);
		end
	end

	// Fold the angle onto the quarter-wave table
	always_comb begin
		priority if (angle_q <= 9'd90) begin
			fold_diff = angle_q;
			sin_neg   = 1'b0;
		end else if (angle_q <= 9'd180) begin
			fold_diff = 9'd180 - angle_q;
			sin_neg   = 1'b0;
		end else if (angle_q <= 9'd270) begin
			fold_diff = angle_q - 9'd180;
			sin_neg   = 1'b1;
		end else begin
			fold_diff = 9'd360 - angle_q;
			sin_neg   = 1'b1;
		end
		sin_idx = fold_diff[6:0];
		if (sin_neg) begin
			sin_val = signed'(SIN_W'(16'd0 - SIN_W'(SIN_Q15[sin_idx])));
		end else begin
			sin_val = signed'(SIN_W'(SIN_Q15[sin_idx]));
		end
	end

	// Multiplier operands
	always_comb begin
		unique case (ctrl.mul_a)
			A_SIN:   mul_a_val = MUL_A_W'(sin_q);
			A_VX:    mul_a_val = vel_x_q;
			A_VY:    mul_a_val = vel_y_q;
			default: mul_a_val = '0;
		endcase
		unique case (ctrl.mul_b)
			B_SPEED: mul_b_val = signed'(MUL_B_W'(speed_q));
			B_W1:    mul_b_val = K_W1;
			B_THIRD: mul_b_val = K_THIRD;
			B_NROOT: mul_b_val = K_NROOT;
			B_ROOT:  mul_b_val = K_ROOT;
			default: mul_b_val = '0;
		endcase
	end

	// Velocity magnitude, truncated toward zero
	always_comb begin
		prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		vel_mag  = VEL_W'(prod_abs >> VEL_SHIFT);
	end

	// Divider front end and one restoring step
	always_comb begin
		acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		div_num = acc_abs[ACC_W-1:PROD_SHIFT];
		rpm_eff = (max_rpm_q == '0) ? CFG_DATA_W'(1) : max_rpm_q;
		dvs     = REM_W'(rpm_eff) << cnt_q;
		rem_ge  = (rem_q >= dvs);
	end

	// Saturation and sign of a finished quotient
	always_comb begin
		drv_lim = neg_q ? LIM_NEG : LIM_POS;
		drv_mag = (sat_q || (quot_q > drv_lim)) ? drv_lim : quot_q;
		drv_val = neg_q ? signed'(DRV_W'(9'd0 - drv_mag)) : signed'(drv_mag);
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= SPEED_RST;
			max_rpm_q   <= MAX_RPM_RST;
			heading_q   <= '0;
			move_q      <= 1'b0;
			stop_q      <= 1'b0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SPEED:   speed_q   <= cfg_data;
					REG_MAX_RPM: max_rpm_q <= cfg_data;
					default:     ;
				endcase
			end
			if (accept) begin
				move_q <= (pkt.command == CMD_MOVE);
				stop_q <= (pkt.command == CMD_STOP);
				if (pkt.data_fresh) begin
					heading_q <= head_new;
				end
			end
			unique case (ctrl.vel_op)
				VEL_STOP: begin
					if (stop_q) begin
						vel_x_q <= '0;
						vel_y_q <= '0;
					end
				end
				VEL_X: begin
					vel_x_q <= prod_q[PROD_W-1] ? signed'(vel_mag)
						: signed'(VEL_W'(20'd0 - vel_mag));
				end
				VEL_Y: begin
					vel_y_q <= prod_q[PROD_W-1] ? signed'(VEL_W'(20'd0 - vel_mag))
						: signed'(vel_mag);
				end
				default: ;
			endcase
			unique case (ctrl.div_op)
				DIV_INIT: cnt_q <= CNT_W'(QUOT_W - 1);
				DIV_STEP: cnt_q <= cnt_q - 1'b1;
				default:  ;
			endcase
			if (ctrl.out_ld && !out_full) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctrl.ang_ld) begin
			angle_q <= ang_red;
		end
		if (ctrl.sin_ld) begin
			sin_q <= sin_val;
		end
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(mul_a_val * mul_b_val);
		end
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  ;
		endcase
		unique case (ctrl.div_op)
			DIV_INIT: begin
				neg_q  <= acc_q[ACC_W-1];
				sat_q  <= (div_num >= (ACC_W-PROD_SHIFT)'({rpm_eff, 9'd0}));
				rem_q  <= div_num[REM_W-1:0];
				quot_q <= '0;
			end
			DIV_STEP: begin
				if (rem_ge) begin
					rem_q <= rem_q - dvs;
				end
				quot_q <= {quot_q[QUOT_W-2:0], rem_ge};
			end
			default: ;
		endcase
		unique case (ctrl.drv_op)
			DRV_ONE:   drv1_q <= drv_val;
			DRV_TWO:   drv2_q <= drv_val;
			DRV_THREE: drv3_q <= drv_val;
			default:   ;
		endcase
		if (ctrl.out_ld && !out_full) begin
			out1_q <= drv1_q;
			out2_q <= drv2_q;
			out3_q <= drv3_q;
		end
	end
endmodule
`default_nettype wire

### rtl/core/omni_wheel_heading_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_heading_drive
// Heading control of a three-wheel omni base from sound-direction packets.
// ----------------------------------------------------------------------------
// Each packet item may carry a new azimuth (the sum of its two bytes, negated
// when the first byte is the smaller) and a command: a command of 1 sets the
// travel velocity to the configured speed along the kept azimuth, a command of
// 90 stops, and any other command keeps the velocity. Every packet gives one
// item of three signed wheel drive values, the velocity passed through the
// fixed three-wheel coupling matrix and scaled by DRIVE_TOP over max_rpm,
// truncated toward zero and clamped. The work is done by a microcoded
// sequencer driving a single shared multiplier, an accumulator and a
// bit-a-cycle restoring divider. A packet is accepted only in the wait step;
// the sine and velocity steps run only when it carries a move command, and
// the next packet is accepted only after the three nine-step divisions and
// the load of the output register. One result is held in an output
// register, so the next packet is accepted while it waits to be taken.
// Configuration writes take effect at once and are meant for idle periods; a
// max_rpm of zero acts as one.
// ----------------------------------------------------------------------------
module omni_wheel_heading_drive #(
	parameter int unsigned DRIVE_TOP = owhd_pkg::DRIVE_TOP_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	owhd_in_if.sink                               pkt,
	owhd_out_if.source                            drive,
	input  wire logic                             cfg_we,
	input  wire logic [owhd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [owhd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import owhd_pkg::*;

	// Control word of the current step and the status that steers its jumps.
	ctrl_t ctrl;
	stat_t stat;

	// The sequencer walks the microcode: a wait step that accepts a packet,
	// the velocity update, then three passes of multiply, accumulate and
	// divide, one for each wheel, and finally the load of the output register.
	owhd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// The datapath holds the configuration, heading and velocity, and the
	// output register that parts the two channels.
	owhd_datapath #(
		.DRIVE_TOP (DRIVE_TOP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pkt      (pkt),
		.drive    (drive)
	);
endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the omni wheel heading drive. Packet items are fed
// from a queue through a randomly gapped driver, and drive items are taken by
// a randomly stalling receiver. A predictor in the bench reproduces the
// heading, velocity and wheel coupling arithmetic and checks every drive item
// field by field, across several speed and max_rpm settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned DRIVE_TOP     = 249;
	localparam int          RESET_CYCLES  = 8;
	localparam int          SETTLE_CYCLES = 60;
	localparam int          LONG_HOLD     = 300;
	localparam int          LIMIT_CYCLES  = 400000;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_ITEMS   = 150;
	localparam int          QUARTER_TURN  = 90;
	localparam int          SPEED_AT_RESET   = 100;
	localparam int          MAX_RPM_AT_RESET = 200;

	// Wheel coupling coefficients in Q1.15
	localparam longint WHEEL_K_TWO_THIRDS = 21846;
	localparam longint WHEEL_K_THIRD      = 10922;
	localparam longint WHEEL_K_ROOT       = 18920;
	localparam int     VEL_FRAC_SHIFT     = 6;
	localparam int     DRIVE_FRAC_SHIFT   = 24;

	// Register indexes that decode to nothing
	localparam logic [owhd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [owhd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	// Commands that neither move nor stop
	localparam logic [7:0] CMD_IDLE_LOW  = 8'd0;
	localparam logic [7:0] CMD_IDLE_HIGH = 8'd255;
	localparam logic [7:0] CMD_NEAR_STOP = 8'd91;

	// sin(k degrees) * 32768 rounded, k = 0..90, the last entry saturated
	localparam int SINE_Q15 [91] = '{
		0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
		5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
		11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
		16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
		21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
		25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
		28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
		30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
		32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
		32767
	};

	typedef struct {
		logic [7:0] az_first;
		logic [7:0] az_second;
		logic [7:0] command;
		logic       data_fresh;
	} packet_t;

	typedef struct {
		logic signed [8:0] one;
		logic signed [8:0] two;
		logic signed [8:0] three;
	} drive_set_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [owhd_pkg::CFG_IDX_W-1:0]    cfg_idx;
	logic [owhd_pkg::CFG_DATA_W-1:0]   cfg_data;

	owhd_in_if  pkt_if ();
	owhd_out_if drive_if ();

	omni_wheel_heading_drive #(
		.DRIVE_TOP(DRIVE_TOP)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt_if),
		.drive   (drive_if),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// Packets still to be offered, and drive items predicted but not yet seen.
	packet_t    packet_queue [$];
	drive_set_t drive_expected [$];

	// The bench's own copy of the block's registers and state.
	int          model_heading;
	int          model_vel_x;
	int          model_vel_y;
	int unsigned model_speed;
	int unsigned model_max_rpm;

	int error_count   = 0;
	int results_taken = 0;
	int cycle_count   = 0;
	int send_wait     = 0;
	int take_wait     = 0;
	bit pkt_fire      = 1'b0;
	bit out_fire      = 1'b0;
	bit no_gaps       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Sine in Q1.15 of any whole-degree angle, folded onto the first quadrant.
	function automatic int sine_deg(int deg);
		int r;
		r = deg % 360;
		if (r < 0)
			r += 360;
		if (r <= 90)
			return SINE_Q15[r];
		else if (r <= 180)
			return SINE_Q15[180 - r];
		else if (r <= 270)
			return -SINE_Q15[r - 180];
		return -SINE_Q15[360 - r];
	endfunction

	// Speed times sine, as Q10.9; the magnitude is truncated so the result
	// rounds toward zero.
	function automatic int speed_times(int s);
		longint mag;
		longint v;
		mag = (s < 0) ? -s : s;
		v = (longint'(model_speed) * mag) >>> VEL_FRAC_SHIFT;
		return (s < 0) ? -int'(v) : int'(v);
	endfunction

	// Scale an exact wheel sum by DRIVE_TOP over max_rpm and clamp it.
	function automatic logic signed [8:0] wheel_drive(longint sum);
		longint rpm;
		longint mag;
		longint q;
		longint lim_pos;
		longint lim_neg;
		rpm = (model_max_rpm == 0) ? 1 : longint'(model_max_rpm);
		mag = (sum < 0) ? -sum : sum;
		q = (mag * longint'(DRIVE_TOP)) / (rpm << DRIVE_FRAC_SHIFT);
		lim_pos = (DRIVE_TOP < 255) ? longint'(DRIVE_TOP) : 255;
		lim_neg = (DRIVE_TOP < 256) ? longint'(DRIVE_TOP) : 256;
		if (sum < 0)
			return 9'(-((q > lim_neg) ? lim_neg : q));
		return 9'((q > lim_pos) ? lim_pos : q);
	endfunction

	// Advance the bench state by one packet and give the drive item it causes.
	function automatic drive_set_t predict_drive(packet_t p);
		int         az_sum;
		longint     x;
		longint     y;
		drive_set_t d;
		if (p.data_fresh) begin
			az_sum = int'(p.az_first) + int'(p.az_second);
			model_heading = (p.az_first >= p.az_second) ? az_sum : -az_sum;
		end
		if (p.command == owhd_pkg::CMD_MOVE) begin
			model_vel_x = -speed_times(sine_deg(model_heading));
			model_vel_y = speed_times(sine_deg(model_heading + QUARTER_TURN));
		end else if (p.command == owhd_pkg::CMD_STOP) begin
			model_vel_x = 0;
			model_vel_y = 0;
		end
		x = model_vel_x;
		y = model_vel_y;
		d.one   = wheel_drive(-WHEEL_K_TWO_THIRDS * x);
		d.two   = wheel_drive(WHEEL_K_THIRD * x - WHEEL_K_ROOT * y);
		d.three = wheel_drive(WHEEL_K_THIRD * x + WHEEL_K_ROOT * y);
		return d;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	// One line for every mismatch, and a count of them.
	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Everything is sampled at the rising edge, before the block's own
	// registers move. The packet is predicted on acceptance, and each drive
	// item taken is compared with the oldest prediction.
	always @(posedge clk) begin
		packet_t    seen;
		drive_set_t want;
		pkt_fire <= pkt_if.valid && pkt_if.ready;
		out_fire <= drive_if.valid && drive_if.ready;
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			seen.az_first   = pkt_if.az_first;
			seen.az_second  = pkt_if.az_second;
			seen.command    = pkt_if.command;
			seen.data_fresh = pkt_if.data_fresh;
			drive_expected.push_back(predict_drive(seen));
		end
		if (arst_n && drive_if.valid && drive_if.ready) begin
			results_taken <= results_taken + 1;
			if (drive_expected.size() == 0) begin
				report_mismatch("drive item with nothing expected, drive_one",
					int'(drive_if.drive_one), 0);
			end else begin
				want = drive_expected.pop_front();
				if (drive_if.drive_one !== want.one)
					report_mismatch("drive_one", int'(drive_if.drive_one), int'(want.one));
				if (drive_if.drive_two !== want.two)
					report_mismatch("drive_two", int'(drive_if.drive_two), int'(want.two));
				if (drive_if.drive_three !== want.three)
					report_mismatch("drive_three", int'(drive_if.drive_three),
						int'(want.three));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Packet driver
	// ------------------------------------------------------------------------

	// Inputs move on the falling edge. An item is held until it has been
	// accepted; after each acceptance a random gap is drawn before the next
	// item is offered.
	always @(negedge clk) begin
		packet_t next_item;
		if (!arst_n) begin
			pkt_if.valid <= 1'b0;
		end else if (pkt_fire || !pkt_if.valid) begin
			if (pkt_fire)
				send_wait = no_gaps ? 0 : $urandom_range(0, 4);
			if (send_wait > 0) begin
				send_wait--;
				pkt_if.valid <= 1'b0;
			end else if (packet_queue.size() != 0) begin
				next_item = packet_queue.pop_front();
				pkt_if.valid      <= 1'b1;
				pkt_if.az_first   <= next_item.az_first;
				pkt_if.az_second  <= next_item.az_second;
				pkt_if.command    <= next_item.command;
				pkt_if.data_fresh <= next_item.data_fresh;
			end else begin
				pkt_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drive receiver
	// ------------------------------------------------------------------------

	// After each drive item the receiver stalls for a random gap. Twice in
	// the run it holds off for a long stretch instead, while the driver keeps
	// offering packets, so that the output register and the input both back
	// up.
	always @(negedge clk) begin
		if (!arst_n) begin
			drive_if.ready <= 1'b0;
		end else begin
			if (out_fire) begin
				if (results_taken == 50 || results_taken == 700)
					take_wait = LONG_HOLD;
				else
					take_wait = no_gaps ? 0 : $urandom_range(0, 4);
			end
			if (take_wait > 0) begin
				take_wait--;
				drive_if.ready <= 1'b0;
			end else begin
				drive_if.ready <= 1'b1;
			end
		end
	end

	// A stuck handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic add_packet(logic [7:0] first, logic [7:0] second, logic [7:0] cmd,
		logic fresh);
		packet_t p;
		p.az_first   = first;
		p.az_second  = second;
		p.command    = cmd;
		p.data_fresh = fresh;
		packet_queue.push_back(p);
	endtask

	// Writes are only issued while the block is idle, so the bench copy of
	// the registers can be updated at once.
	task automatic write_register(logic [owhd_pkg::CFG_IDX_W-1:0] idx,
		logic [owhd_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		case (idx)
			owhd_pkg::REG_SPEED:   model_speed = value;
			owhd_pkg::REG_MAX_RPM: model_max_rpm = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the sender back until every packet has gone in and every drive
	// item has come out, then let the block settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (packet_queue.size() != 0 || pkt_if.valid || drive_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly move and stop commands, so the velocity keeps changing, with
	// equal and extreme azimuth bytes mixed in.
	function automatic packet_t random_packet();
		packet_t p;
		int      pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			p.az_first  = 8'($urandom);
			p.az_second = p.az_first;
		end else if (pick == 1) begin
			p.az_first  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.az_second = 8'($urandom);
		end else begin
			p.az_first  = 8'($urandom);
			p.az_second = 8'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick < 5)
			p.command = owhd_pkg::CMD_MOVE;
		else if (pick < 7)
			p.command = owhd_pkg::CMD_STOP;
		else
			p.command = 8'($urandom);
		p.data_fresh = ($urandom_range(0, 3) != 0);
		return p;
	endfunction

	initial begin
		int phase;
		int n;
		int speed_sel;
		int rpm_sel;

		arst_n               = 1'b0;
		pkt_if.valid         = 1'b0;
		pkt_if.az_first      = '0;
		pkt_if.az_second     = '0;
		pkt_if.command       = '0;
		pkt_if.data_fresh    = 1'b0;
		drive_if.ready       = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = '0;
		cfg_data             = '0;
		model_heading        = 0;
		model_vel_x          = 0;
		model_vel_y          = 0;
		model_speed          = SPEED_AT_RESET;
		model_max_rpm        = MAX_RPM_AT_RESET;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings. The first packet shows the cleared state; the rest
		// walk the heading over the byte extremes, both signs and every
		// quadrant boundary, with stale packets and with commands that keep
		// the velocity.
		add_packet(8'd0, 8'd0, CMD_IDLE_LOW, 1'b0);
		add_packet(8'd0, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd255, 8'd255, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd0, 8'd255, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd255, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		// Stale packet: the bytes are ignored but the move is recomputed.
		add_packet(8'd200, 8'd3, owhd_pkg::CMD_MOVE, 1'b0);
		add_packet(8'd45, 8'd45, owhd_pkg::CMD_STOP, 1'b1);
		add_packet(8'd17, 8'd99, CMD_IDLE_HIGH, 1'b0);
		add_packet(8'd1, 8'd1, owhd_pkg::CMD_MOVE, 1'b0);
		add_packet(8'd90, 8'd90, CMD_NEAR_STOP, 1'b1);
		add_packet(8'd1, 8'd2, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd135, 8'd135, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd0, 8'd90, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd180, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		wait_drained();

		// Full speed against the smallest max_rpm drives every wheel with a nonzero
		// share of the velocity into saturation.
		write_register(owhd_pkg::REG_SPEED, 10'd1023);
		write_register(owhd_pkg::REG_MAX_RPM, 10'd1);
		add_packet(8'd0, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd23, 8'd22, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd105, 8'd105, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd165, 8'd165, owhd_pkg::CMD_MOVE, 1'b1);
		wait_drained();

		// A max_rpm of zero must behave as one.
		write_register(owhd_pkg::REG_SPEED, 10'd1);
		write_register(owhd_pkg::REG_MAX_RPM, 10'd0);
		add_packet(8'd30, 8'd30, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd0, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		wait_drained();

		// Writes to the unused indexes must change nothing; a decoder that
		// drops the upper index bit would clobber max_rpm or the speed here.
		write_register(owhd_pkg::REG_SPEED, 10'd1023);
		write_register(owhd_pkg::REG_MAX_RPM, 10'd1023);
		write_register(REG_SPARE_LO, 10'd0);
		write_register(REG_SPARE_HI, 10'd0);
		add_packet(8'd0, 8'd0, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd60, 8'd60, owhd_pkg::CMD_MOVE, 1'b1);
		add_packet(8'd60, 8'd60, owhd_pkg::CMD_STOP, 1'b0);
		wait_drained();

		write_register(owhd_pkg::REG_SPEED, 10'd0);
		add_packet(8'd10, 8'd20, owhd_pkg::CMD_MOVE, 1'b1);
		wait_drained();

		// Random phases, each under its own setting. Small max_rpm values
		// alternate with wide ones so that both clamped and unclamped drive
		// values are common, and one phase runs with no gaps on either side.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			speed_sel = (phase == 1) ? 1023 : (phase == 2) ? 0 : $urandom_range(0, 1023);
			if (phase == 3)
				rpm_sel = 1;
			else if (phase == 4)
				rpm_sel = 1023;
			else if (phase == 5)
				rpm_sel = 0;
			else if (phase % 2 == 1)
				rpm_sel = $urandom_range(1, 16);
			else
				rpm_sel = $urandom_range(1, 1023);
			write_register(owhd_pkg::REG_SPEED, 10'(speed_sel));
			write_register(owhd_pkg::REG_MAX_RPM, 10'(rpm_sel));
			if (phase == RANDOM_PHASES - 1)
				write_register(REG_SPARE_HI, 10'($urandom));
			no_gaps <= (phase == 6);
			for (n = 0; n < PHASE_ITEMS; n++)
				packet_queue.push_back(random_packet());
			wait_drained();
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
